[design/round_robin_time_slice_scheduler_assert.svh]
// Assertion macros shared by the scheduler RTL.
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_ASSERT_SVH

// Checks an implication property on the rising clock edge, outside reset.
`define RRTS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition holds at every clock edge outside reset.
`define RRTS_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`endif

[design/rrts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rrts_pkg;
	localparam int MaxProcesses = 16;
	localparam int TimeW = 24;
	localparam logic [TimeW-1:0] QuantumReset = 24'd2500;
	localparam logic [TimeW-1:0] TimeMax = 24'hFFFFFF;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_SLICE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [2:0] ST_LOADED   = 3'd0;
	localparam logic [2:0] ST_REJECTED = 3'd1;
	localparam logic [2:0] ST_RAN      = 3'd2;
	localparam logic [2:0] ST_ALL_DONE = 3'd3;
	localparam logic [2:0] ST_CLEARED  = 3'd4;

	typedef struct packed {
		logic [TimeW-1:0] waiting;
		logic [TimeW-1:0] turnaround;
		logic             finished;
		logic [TimeW-1:0] slice_end;
		logic [TimeW-1:0] slice_start;
		logic [3:0]       slot;
		logic [2:0]       status;
	} result_t;
endpackage
`default_nettype wire

[design/rrts_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module rrts_ram #(
	parameter int Width = 8,
	parameter int Depth = 16,
	parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  wire              clk,
	input  wire              we,
	input  wire  [AddrW-1:0] waddr,
	input  wire  [Width-1:0] wdata,
	input  wire  [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[design/round_robin_time_slice_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Item
// s_*       in         cmd, arrival, burst
// m_*       out        status, slot, slice start, slice end, finished, turnaround, waiting
// APB       in/out     time_quantum at byte address 0
//
// The admission scan reads one job table entry a cycle from a RAM with one
// write port and one read port, and the job table is scanned a second time
// when time has to jump ahead to the earliest pending arrival.
// Reset is asynchronous and needs no clearing pass; the job and ring RAMs are
// only read at entries already written. A full output register holds the
// block in its last state until the item is taken.
module round_robin_time_slice_scheduler #(
	parameter int MAX_PROCESSES = rrts_pkg::MaxProcesses
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [55:0]  s_tdata,   // cmd[1:0], arrival[25:2], burst[49:26]
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [103:0] m_tdata,   // status, slot, slice start, slice end, finished,
	                                // turnaround, waiting (from bit 0 up)
	input  wire          psel,
	input  wire          penable,
	input  wire          pwrite,
	input  wire  [2:0]   paddr,
	input  wire  [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import rrts_pkg::*;

	localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int CW = $clog2(MAX_PROCESSES + 1);
	localparam int JW = 3 * TimeW;
	localparam logic [CW-1:0] CntMax = CW'(MAX_PROCESSES);
	localparam logic [IW-1:0] IdxLast = IW'(MAX_PROCESSES - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_DISP = 3'd2;
	localparam logic [2:0] S_POP  = 3'd3;
	localparam logic [2:0] S_EXEC = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	logic [2:0]       state_q;
	logic [TimeW-1:0] quantum_q;
	logic [MAX_PROCESSES-1:0] queued_q;
	logic [IW-1:0]    head_q, tail_q;
	logic [CW-1:0]    count_q, loaded_q, done_q;
	logic [TimeW-1:0] now_q;
	logic [CW-1:0]    scan_idx_q;
	logic             pass_q;
	logic             valid_s1;
	logic [IW-1:0]    idx_s1;
	logic             found_q;
	logic [TimeW-1:0] best_q;
	logic [IW-1:0]    slot_q;
	logic [TimeW-1:0] arr_q, bur_q, rem_q, start_q, end_q;
	result_t          res_q;
	logic             m_tvalid_q;
	logic [103:0]     m_tdata_q;

	logic [1:0]       in_cmd;
	logic [TimeW-1:0] in_arr, in_bur;
	assign in_cmd = s_tdata[1:0];
	assign in_arr = s_tdata[25:2];
	assign in_bur = s_tdata[49:26];

	logic accept;
	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {8'b0, quantum_q} : 32'b0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QuantumReset;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			quantum_q <= pwdata[TimeW-1:0];
		end
	end

	// Memories: job table {arrival, burst, remaining} and the ready ring.
	logic          job_we;
	logic [IW-1:0] job_waddr, job_raddr;
	logic [JW-1:0] job_wdata, job_rdata;
	logic          ring_we;
	logic [IW-1:0] ring_wdata, ring_rdata;

	rrts_ram #(.Width(JW), .Depth(MAX_PROCESSES)) u_job_ram (
		.clk(clk), .we(job_we), .waddr(job_waddr), .wdata(job_wdata),
		.raddr(job_raddr), .rdata(job_rdata)
	);
	rrts_ram #(.Width(IW), .Depth(MAX_PROCESSES)) u_ring_ram (
		.clk(clk), .we(ring_we), .waddr(tail_q), .wdata(ring_wdata),
		.raddr(head_q), .rdata(ring_rdata)
	);

	logic [TimeW-1:0] rd_arr, rd_rem;
	assign rd_arr = job_rdata[JW-1 -: TimeW];
	assign rd_rem = job_rdata[TimeW-1:0];

	logic admit_hit, pend_hit;
	assign admit_hit = valid_s1 && rd_arr <= now_q && rd_rem != '0 && !queued_q[idx_s1];
	assign pend_hit  = valid_s1 && rd_rem != '0 && rd_arr > now_q;

	logic scan_issue;
	assign scan_issue = (state_q == S_SCAN) && (scan_idx_q < loaded_q);

	// Slice arithmetic.
	logic [TimeW-1:0] q_eff, run;
	logic [TimeW:0]   sum;
	assign q_eff = (quantum_q == '0) ? TimeW'(1) : quantum_q;
	assign run   = (rd_rem < q_eff) ? rd_rem : q_eff;
	assign sum   = {1'b0, now_q} + {1'b0, run};

	logic [TimeW-1:0] tat;
	assign tat = end_q - arr_q;

	logic [IW+3:0] slot_ext;
	assign slot_ext = {4'b0, slot_q};
	logic [CW+3:0] load_ext;
	assign load_ext = {4'b0, loaded_q};

	always_comb begin
		job_we    = 1'b0;
		job_waddr = loaded_q[IW-1:0];
		job_wdata = {in_arr, in_bur, in_bur};
		job_raddr = scan_idx_q[IW-1:0];
		ring_we   = 1'b0;
		ring_wdata = slot_q;
		if (accept && in_cmd == CMD_LOAD && loaded_q < CntMax) begin
			job_we = 1'b1;
		end
		if (state_q == S_POP) begin
			job_raddr = ring_rdata;
		end
		if (state_q == S_EXEC) begin
			job_we    = 1'b1;
			job_waddr = slot_q;
			job_wdata = {rd_arr, job_rdata[2*TimeW-1 -: TimeW], rd_rem - run};
		end
		if (state_q == S_SCAN && admit_hit) begin
			ring_we    = 1'b1;
			ring_wdata = idx_s1;
		end
		if (state_q == S_FIN && rem_q != '0) begin
			ring_we = 1'b1;
		end
	end

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
		ring_next = (p == IdxLast) ? '0 : p + IW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			queued_q   <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			loaded_q   <= '0;
			done_q     <= '0;
			now_q      <= '0;
			scan_idx_q <= '0;
			pass_q     <= 1'b0;
			valid_s1   <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			valid_s1 <= scan_issue;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q <= '0;
						case (in_cmd)
							CMD_LOAD: begin
								state_q <= S_EMIT;
								if (loaded_q >= CntMax) begin
									res_q.status <= ST_REJECTED;
								end else begin
									res_q.status <= ST_LOADED;
									res_q.slot   <= load_ext[3:0];
									queued_q[loaded_q[IW-1:0]] <= 1'b0;
									loaded_q <= loaded_q + CW'(1);
									if (in_bur == '0) begin
										done_q <= done_q + CW'(1);
									end
								end
							end
							CMD_CLEAR: begin
								state_q  <= S_EMIT;
								res_q.status <= ST_CLEARED;
								queued_q <= '0;
								head_q   <= '0;
								tail_q   <= '0;
								count_q  <= '0;
								loaded_q <= '0;
								done_q   <= '0;
								now_q    <= '0;
							end
							CMD_SLICE: begin
								if (done_q >= loaded_q) begin
									state_q <= S_EMIT;
									res_q.status <= ST_ALL_DONE;
								end else begin
									state_q    <= S_SCAN;
									scan_idx_q <= '0;
									pass_q     <= 1'b0;
									found_q    <= 1'b0;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						scan_idx_q <= scan_idx_q + CW'(1);
						idx_s1     <= scan_idx_q[IW-1:0];
					end
					if (admit_hit) begin
						queued_q[idx_s1] <= 1'b1;
						tail_q  <= ring_next(tail_q);
						count_q <= count_q + CW'(1);
					end
					if (pend_hit && (!found_q || rd_arr < best_q)) begin
						found_q <= 1'b1;
						best_q  <= rd_arr;
					end
					if (!scan_issue && !valid_s1) begin
						if (count_q != '0) begin
							state_q <= S_DISP;
						end else if (!pass_q && found_q) begin
							// Nothing ready: jump to the earliest arrival and rescan.
							now_q      <= best_q;
							pass_q     <= 1'b1;
							scan_idx_q <= '0;
						end else begin
							state_q <= S_EMIT;
							res_q.status <= ST_ALL_DONE;
						end
					end
				end
				S_DISP: begin
					state_q <= S_POP;
				end
				S_POP: begin
					slot_q  <= ring_rdata;
					head_q  <= ring_next(head_q);
					count_q <= count_q - CW'(1);
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					arr_q   <= rd_arr;
					bur_q   <= job_rdata[2*TimeW-1 -: TimeW];
					rem_q   <= rd_rem - run;
					start_q <= now_q;
					end_q   <= sum[TimeW] ? TimeMax : sum[TimeW-1:0];
					now_q   <= sum[TimeW] ? TimeMax : sum[TimeW-1:0];
					state_q <= S_FIN;
				end
				S_FIN: begin
					res_q.status      <= ST_RAN;
					res_q.slot        <= slot_ext[3:0];
					res_q.slice_start <= start_q;
					res_q.slice_end   <= end_q;
					if (rem_q != '0) begin
						tail_q  <= ring_next(tail_q);
						count_q <= count_q + CW'(1);
					end else begin
						queued_q[slot_q] <= 1'b0;
						done_q <= done_q + CW'(1);
						res_q.finished   <= 1'b1;
						res_q.turnaround <= tat;
						res_q.waiting    <= (tat > bur_q) ? tat - bur_q : '0;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_EMIT && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= res_q;
		end
	end
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`include "round_robin_time_slice_scheduler_assert.svh"

	`RRTS_ALWAYS(a_ring_bound, count_q <= CntMax, "ready ring count above capacity")
	`RRTS_ALWAYS(a_done_bound, done_q <= loaded_q, "more jobs finished than loaded")
	`RRTS_ASSERT(a_pop_nonempty, (state_q == S_DISP) |-> (count_q != '0), "pop from empty ring")
	`RRTS_ASSERT(a_fin_emit, (state_q == S_FIN) |=> (state_q == S_EMIT), "slice result lost")
endmodule
`default_nettype wire
